/* sv/assert_macros.svh */
// Assertion macros shared by the radio mode sequencer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is held
`define RMS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("radio mode sequencer: assertion failed");

// Implication checked in the same cycle, off while reset is held
`define RMS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("radio mode sequencer: implication failed");

// Implication checked in the following cycle, off while reset is held
`define RMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("radio mode sequencer: next-cycle implication failed");

`endif

/* sv/rms_pkg.sv */
// Types and constants of the radio mode sequencer
package rms_pkg;

  // Request codes
  localparam logic [2:0] REQ_SLEEP   = 3'd0;
  localparam logic [2:0] REQ_PWR_UP  = 3'd1;
  localparam logic [2:0] REQ_OPEN_RX = 3'd2;
  localparam logic [2:0] REQ_OPEN_TX = 3'd3;
  localparam logic [2:0] REQ_SEND    = 3'd4;
  localparam logic [2:0] REQ_CLOSE   = 3'd5;
  localparam logic [2:0] REQ_IRQ     = 3'd6;

  // Operating modes
  localparam logic [2:0] MODE_PD  = 3'd0;
  localparam logic [2:0] MODE_SB1 = 3'd1;
  localparam logic [2:0] MODE_SB2 = 3'd2;
  localparam logic [2:0] MODE_RX  = 3'd3;
  localparam logic [2:0] MODE_TX  = 3'd4;

  // Settle times in delay ticks
  localparam int unsigned WAIT_W = 12;
  localparam logic [WAIT_W-1:0] T_PWRUP = 12'd2000;
  localparam logic [WAIT_W-1:0] T_PLL   = 12'd350;
  localparam logic [WAIT_W-1:0] T_PULSE = 12'd15;
  localparam logic [WAIT_W-1:0] T_SEND  = 12'd180;

  // Register map
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic REG_BURST_TX = 1'b0;
  localparam logic REG_BURST_RX = 1'b1;

  typedef struct packed {
    logic [2:0] req_type;
    logic       tx_fifo_empty;
    logic       rx_fifo_empty;
    logic       irq_rx;
    logic       irq_tx;
    logic       irq_max_rt;
  } item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       ce;
    logic       prim_rx;
    logic       pwr_up;
  } state_t;

  typedef struct packed {
    logic burst_tx;
    logic burst_rx;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic              ce_level;
    logic              prim_rx;
    logic              pwr_up;
    logic [WAIT_W-1:0] wait_ticks;
    logic              ce_pulsed;
    logic              flush_fifos;
    logic              event_valid;
    logic [2:0]        event_code;
    logic              clear_irq;
  } result_t;

endpackage

/* sv/rms_cfg.sv */
// Configuration register block on the APB-style port
module rms_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rms_pkg::CFG_AW-1:0] paddr,
  input  logic [rms_pkg::CFG_DW-1:0] pwdata,
  output logic [rms_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output rms_pkg::cfg_t              cfg_o
);

  rms_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic          reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  // registers sit on 4-byte steps
  assign reg_sel = paddr[2];

  // write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        rms_pkg::REG_BURST_TX: cfg_d.burst_tx = pwdata[0];
        rms_pkg::REG_BURST_RX: cfg_d.burst_rx = pwdata[0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      rms_pkg::REG_BURST_TX: prdata[0] = cfg_q.burst_tx;
      rms_pkg::REG_BURST_RX: prdata[0] = cfg_q.burst_rx;
      default:               prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/rms_step.sv */
// Decision logic: next mode state and result for one request
module rms_step (
  input  rms_pkg::state_t  cur_i,
  input  rms_pkg::item_t   item_i,
  input  rms_pkg::cfg_t    cfg_i,
  output rms_pkg::state_t  nxt_o,
  output rms_pkg::result_t res_o
);

  typedef struct packed {
    rms_pkg::state_t                 st;
    logic [rms_pkg::WAIT_W-1:0]      w;
  } sb_t;

  // move to standby, with the wait that costs
  function automatic sb_t go_standby(rms_pkg::state_t s);
    sb_t r;
    r.st = s;
    r.w  = '0;
    if (s.mode != rms_pkg::MODE_SB1) begin
      if (s.mode == rms_pkg::MODE_PD) begin
        r.st.pwr_up = 1'b1;
        r.w         = rms_pkg::T_PWRUP;
      end else begin
        r.st.ce = 1'b0;
      end
      r.st.mode = rms_pkg::MODE_SB1;
    end
    return r;
  endfunction

  sb_t                        sb;
  rms_pkg::state_t            nxt;
  logic [rms_pkg::WAIT_W-1:0] wait_t;
  logic                       pulsed, flush, ev, clr, irq_sb;
  logic [2:0]                 code;

  assign sb = go_standby(cur_i);

  // interrupt returns to standby when its FIFO condition holds and the matching burst mode is off
  assign irq_sb = (item_i.irq_tx && item_i.tx_fifo_empty && !cfg_i.burst_tx) ||
                  (item_i.irq_rx && !item_i.rx_fifo_empty && !cfg_i.burst_rx);

  // per-request update
  always_comb begin
    nxt    = cur_i;
    wait_t = '0;
    pulsed = 1'b0;
    flush  = 1'b0;
    ev     = 1'b0;
    code   = '0;
    clr    = 1'b0;
    unique case (item_i.req_type)
      rms_pkg::REQ_SLEEP: begin
        flush = 1'b1;
        if (cur_i.mode != rms_pkg::MODE_PD) begin
          nxt.ce     = 1'b0;
          nxt.pwr_up = 1'b0;
          nxt.mode   = rms_pkg::MODE_PD;
        end
      end
      rms_pkg::REQ_PWR_UP: begin
        flush  = 1'b1;
        nxt    = sb.st;
        wait_t = sb.w;
      end
      rms_pkg::REQ_OPEN_RX: begin
        if (cur_i.mode != rms_pkg::MODE_RX) begin
          nxt         = sb.st;
          nxt.ce      = 1'b1;
          nxt.prim_rx = 1'b1;
          nxt.mode    = rms_pkg::MODE_RX;
          wait_t      = sb.w + rms_pkg::T_PLL;
        end
      end
      rms_pkg::REQ_OPEN_TX: begin
        if (cur_i.mode != rms_pkg::MODE_TX) begin
          nxt         = sb.st;
          nxt.ce      = 1'b1;
          nxt.prim_rx = 1'b0;
          nxt.mode    = item_i.tx_fifo_empty ? rms_pkg::MODE_SB2 : rms_pkg::MODE_TX;
          wait_t      = sb.w + rms_pkg::T_PLL;
        end
      end
      rms_pkg::REQ_SEND: begin
        nxt         = sb.st;
        nxt.prim_rx = 1'b0;
        nxt.ce      = 1'b0;
        nxt.mode    = item_i.tx_fifo_empty ? rms_pkg::MODE_SB2 : rms_pkg::MODE_SB1;
        pulsed      = 1'b1;
        wait_t      = sb.w + rms_pkg::T_PULSE + rms_pkg::T_SEND;
      end
      rms_pkg::REQ_CLOSE: begin
        nxt    = sb.st;
        wait_t = sb.w;
      end
      rms_pkg::REQ_IRQ: begin
        // a second standby move after the first costs nothing
        if (irq_sb) begin
          nxt    = sb.st;
          wait_t = sb.w;
        end
        ev   = 1'b1;
        code = {item_i.irq_max_rt, item_i.irq_tx, item_i.irq_rx};
        clr  = 1'b1;
      end
      default: begin
        nxt = cur_i;
      end
    endcase
  end

  assign nxt_o = nxt;

  // result fields
  always_comb begin
    res_o.mode        = nxt.mode;
    res_o.ce_level    = nxt.ce;
    res_o.prim_rx     = nxt.prim_rx;
    res_o.pwr_up      = nxt.pwr_up;
    res_o.wait_ticks  = wait_t;
    res_o.ce_pulsed   = pulsed;
    res_o.flush_fifos = flush;
    res_o.event_valid = ev;
    res_o.event_code  = code;
    res_o.clear_irq   = clr;
  end

endmodule

/* sv/radio_mode_sequencer.sv */
// Top level of the radio mode sequencer: input stage, mode state and result register
// Path: a request passes the input register, then the result register, before its result is
//   valid; the mode state is updated as the request leaves the input stage.
// Throughput: one request per cycle, sustained, while the result side takes one per cycle.
// Reset: rst_ni clears both stages, the mode state (power down, all lines low) and the
//   burst registers; the block takes requests in the first cycle after reset is released.
`include "assert_macros.svh"

module radio_mode_sequencer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rms_pkg::CFG_AW-1:0] paddr,
  input  logic [rms_pkg::CFG_DW-1:0] pwdata,
  output logic [rms_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 req_type_i,
  input  logic                       tx_fifo_empty_i,
  input  logic                       rx_fifo_empty_i,
  input  logic                       irq_rx_i,
  input  logic                       irq_tx_i,
  input  logic                       irq_max_rt_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 mode_o,
  output logic                       ce_level_o,
  output logic                       prim_rx_o,
  output logic                       pwr_up_o,
  output logic [rms_pkg::WAIT_W-1:0] wait_ticks_o,
  output logic                       ce_pulsed_o,
  output logic                       flush_fifos_o,
  output logic                       event_valid_o,
  output logic [2:0]                 event_code_o,
  output logic                       clear_irq_o
);

  rms_pkg::cfg_t    cfg;
  rms_pkg::item_t   in_item;
  rms_pkg::item_t   s1_item_q;
  logic             s1_valid_q;
  logic             out_valid_q;
  rms_pkg::result_t res_q, res_d;
  rms_pkg::state_t  state_q, state_d;
  logic             out_free, s1_adv, in_acc;

  rms_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_item.req_type      = req_type_i;
  assign in_item.tx_fifo_empty = tx_fifo_empty_i;
  assign in_item.rx_fifo_empty = rx_fifo_empty_i;
  assign in_item.irq_rx        = irq_rx_i;
  assign in_item.irq_tx        = irq_tx_i;
  assign in_item.irq_max_rt    = irq_max_rt_i;

  // handshake: an item moves on when the stage ahead is free or emptying
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  rms_step u_step (
    .cur_i  (state_q),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .nxt_o  (state_d),
    .res_o  (res_d)
  );

  // control and mode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q.mode    <= rms_pkg::MODE_PD;
      state_q.ce      <= 1'b0;
      state_q.prim_rx <= 1'b0;
      state_q.pwr_up  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_item;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign mode_o        = res_q.mode;
  assign ce_level_o    = res_q.ce_level;
  assign prim_rx_o     = res_q.prim_rx;
  assign pwr_up_o      = res_q.pwr_up;
  assign wait_ticks_o  = res_q.wait_ticks;
  assign ce_pulsed_o   = res_q.ce_pulsed;
  assign flush_fifos_o = res_q.flush_fifos;
  assign event_valid_o = res_q.event_valid;
  assign event_code_o  = res_q.event_code;
  assign clear_irq_o   = res_q.clear_irq;

  // power bit follows the mode: low exactly in power down
  `RMS_ASSERT(a_pwr_mode, clk_i, rst_ni, (state_q.mode == rms_pkg::MODE_PD) == !state_q.pwr_up)
  // mode state moves only when an item leaves the input stage
  `RMS_ASSERT_NEXT(a_state_hold, clk_i, rst_ni, !s1_adv, $stable(state_q))
  // a single send ends in standby with chip enable low
  `RMS_ASSERT_IMPL(a_send_sb, clk_i, rst_ni, out_valid_o && ce_pulsed_o,
    !ce_level_o && (mode_o == rms_pkg::MODE_SB1 || mode_o == rms_pkg::MODE_SB2))
  // no interrupt report without an interrupt request
  `RMS_ASSERT_IMPL(a_evt_code, clk_i, rst_ni, out_valid_o && !event_valid_o,
    event_code_o == 3'd0 && !clear_irq_o)
  // settle wait never exceeds power-up plus PLL lock
  `RMS_ASSERT_IMPL(a_wait_max, clk_i, rst_ni, out_valid_o,
    wait_ticks_o <= rms_pkg::T_PWRUP + rms_pkg::T_PLL)

endmodule

/* sim/tb_radio_mode_sequencer.sv */
// Self-checking testbench of the radio mode sequencer: directed table, then random requests
`timescale 1ns / 100ps

module tb_radio_mode_sequencer;
  import rms_pkg::*;

  // Unused request code: the block must leave everything as it is
  localparam logic [2:0] REQ_NONE = 3'd7;

  localparam logic [CFG_AW-1:0] ADDR_BURST_TX = {REG_BURST_TX, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_BURST_RX = {REG_BURST_RX, 2'b00};

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_ITEMS  = 360;
  localparam int unsigned QUIET_AFTER  = 200;
  localparam int unsigned SETTLE_TICKS = 4;
  localparam int unsigned HOLD_CYCLES  = 64;

  typedef struct {
    item_t   req;
    bit      typed;
    result_t want;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata, prdata;

  logic              in_valid_i, in_ready_o;
  logic [2:0]        req_type_i;
  logic              tx_fifo_empty_i, rx_fifo_empty_i;
  logic              irq_rx_i, irq_tx_i, irq_max_rt_i;

  logic              out_valid_o, out_ready_i;
  logic [2:0]        mode_o;
  logic              ce_level_o, prim_rx_o, pwr_up_o;
  logic [WAIT_W-1:0] wait_ticks_o;
  logic              ce_pulsed_o, flush_fifos_o, event_valid_o;
  logic [2:0]        event_code_o;
  logic              clear_irq_o;

  // Predictor state and register copy
  state_t radio;
  cfg_t   burst_cfg;

  result_t     pending_results[$];
  script_row_t script[$];

  int unsigned mismatches   = 0;
  int unsigned sent_count   = 0;
  int unsigned checked      = 0;
  int unsigned gap_pct      = 25;
  bit          quiet        = 1'b0;
  bit          held_off     = 1'b0;
  int unsigned cycles       = 0;

  radio_mode_sequencer dut (.*);

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor: move to standby, returning the settle cost
  function automatic logic [WAIT_W-1:0] settle_to_standby();
    logic [WAIT_W-1:0] cost;
    cost = '0;
    if (radio.mode == MODE_SB1) return cost;
    if (radio.mode == MODE_PD) begin
      radio.pwr_up = 1'b1;
      cost = T_PWRUP;
    end else begin
      radio.ce = 1'b0;
    end
    radio.mode = MODE_SB1;
    return cost;
  endfunction

  // Predictor: one request in, one result out
  function automatic result_t step_radio(item_t it);
    result_t r;
    r = '0;
    case (it.req_type)
      REQ_SLEEP: begin
        r.flush_fifos = 1'b1;
        if (radio.mode != MODE_PD) begin
          radio.ce     = 1'b0;
          radio.pwr_up = 1'b0;
          radio.mode   = MODE_PD;
        end
      end
      REQ_PWR_UP: begin
        r.flush_fifos = 1'b1;
        r.wait_ticks  = settle_to_standby();
      end
      REQ_OPEN_RX: begin
        if (radio.mode != MODE_RX) begin
          r.wait_ticks  = settle_to_standby() + T_PLL;
          radio.ce      = 1'b1;
          radio.prim_rx = 1'b1;
          radio.mode    = MODE_RX;
        end
      end
      REQ_OPEN_TX: begin
        if (radio.mode != MODE_TX) begin
          r.wait_ticks  = settle_to_standby() + T_PLL;
          radio.ce      = 1'b1;
          radio.prim_rx = 1'b0;
          radio.mode    = it.tx_fifo_empty ? MODE_SB2 : MODE_TX;
        end
      end
      REQ_SEND: begin
        r.wait_ticks  = settle_to_standby() + T_PULSE + T_SEND;
        radio.prim_rx = 1'b0;
        r.ce_pulsed   = 1'b1;
        radio.ce      = 1'b0;
        radio.mode    = it.tx_fifo_empty ? MODE_SB2 : MODE_SB1;
      end
      REQ_CLOSE: r.wait_ticks = settle_to_standby();
      REQ_IRQ: begin
        // both return conditions are tested one after the other
        if (it.irq_tx && it.tx_fifo_empty && !burst_cfg.burst_tx)
          r.wait_ticks += settle_to_standby();
        if (it.irq_rx && !it.rx_fifo_empty && !burst_cfg.burst_rx)
          r.wait_ticks += settle_to_standby();
        r.event_valid = 1'b1;
        r.event_code  = {it.irq_max_rt, it.irq_tx, it.irq_rx};
        r.clear_irq   = 1'b1;
      end
      default: ;
    endcase
    r.mode     = radio.mode;
    r.ce_level = radio.ce;
    r.prim_rx  = radio.prim_rx;
    r.pwr_up   = radio.pwr_up;
    return r;
  endfunction

  // flags: txe rxe irx itx imr
  function automatic script_row_t row(logic [2:0] rq, logic [4:0] flags,
                                      bit typed = 1'b0, result_t want = '0);
    script_row_t s;
    s.req   = {rq, flags};
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  // Random request, biased towards mode changes and interrupts
  function automatic item_t random_request();
    item_t       it;
    logic [7:0]  bits;
    int unsigned pick;
    bits = 8'($urandom());
    it   = bits;
    pick = $urandom_range(0, 99);
    if (pick < 8)       it.req_type = REQ_SLEEP;
    else if (pick < 18) it.req_type = REQ_PWR_UP;
    else if (pick < 33) it.req_type = REQ_OPEN_RX;
    else if (pick < 48) it.req_type = REQ_OPEN_TX;
    else if (pick < 63) it.req_type = REQ_SEND;
    else if (pick < 73) it.req_type = REQ_CLOSE;
    else if (pick < 98) it.req_type = REQ_IRQ;
    else                it.req_type = REQ_NONE;
    return it;
  endfunction

  // Offer one item, wait for acceptance, queue its expected result
  task automatic issue_request(item_t req, bit typed, result_t want);
    result_t predicted;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= req.req_type;
    tx_fifo_empty_i <= req.tx_fifo_empty;
    rx_fifo_empty_i <= req.rx_fifo_empty;
    irq_rx_i        <= req.irq_rx;
    irq_tx_i        <= req.irq_tx;
    irq_max_rt_i    <= req.irq_max_rt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = step_radio(req);
    pending_results.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  // Register write: setup, access, then back to idle
  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Burst settings change only once the block has drained
  task automatic apply_bursts(cfg_t c);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
    write_reg(ADDR_BURST_TX, CFG_DW'(c.burst_tx));
    write_reg(ADDR_BURST_RX, CFG_DW'(c.burst_rx));
    burst_cfg = c;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: compare each accepted item with the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: mode %0d", mode_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("mode", want.mode, mode_o);
        check_field("ce_level", want.ce_level, ce_level_o);
        check_field("prim_rx", want.prim_rx, prim_rx_o);
        check_field("pwr_up", want.pwr_up, pwr_up_o);
        check_field("wait_ticks", want.wait_ticks, wait_ticks_o);
        check_field("ce_pulsed", want.ce_pulsed, ce_pulsed_o);
        check_field("flush_fifos", want.flush_fifos, flush_fifos_o);
        check_field("event_valid", want.event_valid, event_valid_o);
        check_field("event_code", want.event_code, event_code_o);
        check_field("clear_irq", want.clear_irq, clear_irq_o);
        checked++;
      end
    end
  end

  // Result side back-pressure, with one long hold-off to fill the block
  initial begin : result_sink
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held_off && !quiet && sent_count >= 150) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Run limit
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("radio_mode_sequencer verification failed");
    $finish;
  end

  initial begin : stimulus
    cfg_t burst_plan [4];
    burst_plan = '{'{1'b1, 1'b1}, '{1'b1, 1'b0}, '{1'b0, 1'b1}, '{1'b0, 1'b0}};

    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    req_type_i      = REQ_SLEEP;
    tx_fifo_empty_i = 1'b0;
    rx_fifo_empty_i = 1'b0;
    irq_rx_i        = 1'b0;
    irq_tx_i        = 1'b0;
    irq_max_rt_i    = 1'b0;
    radio           = '{mode: MODE_PD, default: '0};
    burst_cfg       = '0;

    // Directed table; typed expectations start from the reset state
    script.push_back(row(REQ_SLEEP,   5'b00000, 1'b1,
                         '{mode: MODE_PD, flush_fifos: 1'b1, default: '0}));
    script.push_back(row(REQ_NONE,    5'b11111, 1'b1, '{mode: MODE_PD, default: '0}));
    script.push_back(row(REQ_PWR_UP,  5'b00000, 1'b1,
                         '{mode: MODE_SB1, pwr_up: 1'b1, wait_ticks: T_PWRUP,
                           flush_fifos: 1'b1, default: '0}));
    script.push_back(row(REQ_PWR_UP,  5'b00000, 1'b1,
                         '{mode: MODE_SB1, pwr_up: 1'b1, flush_fifos: 1'b1, default: '0}));
    script.push_back(row(REQ_OPEN_RX, 5'b00000));
    // already in receive
    script.push_back(row(REQ_OPEN_RX, 5'b11111));
    script.push_back(row(REQ_IRQ,     5'b00100));
    script.push_back(row(REQ_OPEN_TX, 5'b00000));
    // already in transmit
    script.push_back(row(REQ_OPEN_TX, 5'b10000));
    script.push_back(row(REQ_IRQ,     5'b10011));
    // open tx with empty queue lands in standby queue empty
    script.push_back(row(REQ_OPEN_TX, 5'b10000));
    script.push_back(row(REQ_SEND,    5'b10000));
    script.push_back(row(REQ_OPEN_RX, 5'b00000));
    script.push_back(row(REQ_SEND,    5'b00000));
    script.push_back(row(REQ_CLOSE,   5'b00000));
    script.push_back(row(REQ_SLEEP,   5'b00000));
    // interrupt from power down with both return conditions met
    script.push_back(row(REQ_IRQ,     5'b10110));
    script.push_back(row(REQ_SLEEP,   5'b00000));
    script.push_back(row(REQ_OPEN_TX, 5'b00000, 1'b1,
                         '{mode: MODE_TX, ce_level: 1'b1, pwr_up: 1'b1,
                           wait_ticks: T_PWRUP + T_PLL, default: '0}));
    script.push_back(row(REQ_SEND,    5'b01111));
    script.push_back(row(REQ_IRQ,     5'b01000));
    script.push_back(row(REQ_IRQ,     5'b01111));
    script.push_back(row(REQ_SLEEP,   5'b00000, 1'b1,
                         '{mode: MODE_PD, flush_fifos: 1'b1, default: '0}));
    script.push_back(row(REQ_CLOSE,   5'b00000, 1'b1,
                         '{mode: MODE_SB1, pwr_up: 1'b1, wait_ticks: T_PWRUP, default: '0}));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) issue_request(script[i].req, script[i].typed, script[i].want);
    in_valid_i <= 1'b0;

    // Random phases, one per burst setting; idling varies, none at the very end
    for (int ph = 0; ph < 4; ph++) begin
      apply_bursts(burst_plan[ph]);
      gap_pct = (ph == 1) ? 0 : (ph == 2) ? 40 : 20;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == QUIET_AFTER) quiet = 1'b1;
        issue_request(random_request(), 1'b0, '0);
      end
      in_valid_i <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);

    $display("%0d requests sent over four burst settings, %0d results compared", sent_count,
             checked);
    $display("long result hold-off taken: %0d, field mismatches: %0d", held_off, mismatches);
    if (mismatches == 0) begin
      $display("radio_mode_sequencer verification clean");
    end else begin
      $display("radio_mode_sequencer verification failed");
    end
    $finish;
  end

endmodule
